>>> sv/isrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrp_pkg
// Shared sizes and codes for the indexed set with random pop.
// ----------------------------------------------------------------------------
package isrp_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_BITS  = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int FUNC_W    = 3;
  localparam int KEY_W     = 32;
  localparam int POS_W     = 6;
  localparam int WORD_W    = 32;
  localparam int ST_W      = 2;
  localparam int DIV_CNT_W = $clog2(WORD_W);

  localparam logic [FUNC_W-1:0] F_INSERT    = 3'd0;
  localparam logic [FUNC_W-1:0] F_ERASE_KEY = 3'd1;
  localparam logic [FUNC_W-1:0] F_TEST      = 3'd2;
  localparam logic [FUNC_W-1:0] F_ERASE_POS = 3'd3;
  localparam logic [FUNC_W-1:0] F_POP       = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef logic [KEY_BITS-1:0] key_t;

endpackage

>>> sv/isrp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module isrp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/indexed_set_random_pop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_set_random_pop
// Bounded key set in a dense RAM with insert, erase, test, erase at slot and
// random pop. Removal moves the last entry into the freed slot.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  command   start, busy        func, key, position, random_word
//  result    done (1 cycle)     status, removed_key, size_after
//
//  Insert, erase key, test: linear search over occupied slots, one RAM read a
//  cycle; erase key then moves the last entry into the found slot. Erase at
//  slot: that move only. Pop: random_word mod count, bit-serial, picks the
//  slot, then the move. Rejected commands finish from idle. No clearing pass
//  after reset. busy is high while a command runs; done cannot be stalled.
// ----------------------------------------------------------------------------
module indexed_set_random_pop
  import isrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] func,
  input  logic [KEY_W-1:0]  key,
  input  logic [POS_W-1:0]  position,
  input  logic [WORD_W-1:0] random_word,
  output logic              done,
  output logic [ST_W-1:0]   status,
  output logic [KEY_W-1:0]  removed_key,
  output logic [CNT_W-1:0]  size_after
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DIV     = 3'd2;
  localparam logic [2:0] S_RM_RD   = 3'd3;
  localparam logic [2:0] S_RM_LAST = 3'd4;
  localparam logic [2:0] S_RM_WR   = 3'd5;

  logic [2:0]           state;
  logic [CNT_W-1:0]     count;
  logic [FUNC_W-1:0]    func_r;
  key_t                 key_r;
  logic [WORD_W-1:0]    word;
  logic [CNT_W-1:0]     idx;
  logic                 cmp_vld;
  logic [ADDR_W-1:0]    cmp_idx;
  logic [ADDR_W-1:0]    slot;
  logic [CNT_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  key_t                 taken;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  key_t                 wdata;
  logic [ADDR_W-1:0]    raddr;
  key_t                 rdata;

  logic                 hit;
  logic                 scan_end;
  logic                 full;
  logic [CNT_W-1:0]     cnt_m1;
  logic [CNT_W:0]       trial;
  logic [CNT_W-1:0]     rem_next;

  assign busy     = (state != S_IDLE);
  assign hit      = cmp_vld && (rdata == key_r);
  assign scan_end = !hit && (idx >= count);
  assign full     = (count == CNT_W'(CAPACITY));
  assign cnt_m1   = count - CNT_W'(1);

  // restoring remainder step, one dividend bit a cycle
  assign trial    = {rem, word[WORD_W-1]};
  assign rem_next = (trial >= {1'b0, count}) ? CNT_W'(trial - {1'b0, count})
                                             : trial[CNT_W-1:0];

  always_comb begin
    case (state)
      S_RM_RD:   raddr = slot;
      S_RM_LAST: raddr = cnt_m1[ADDR_W-1:0];
      default:   raddr = idx[ADDR_W-1:0];
    endcase
    if (state == S_RM_WR) begin
      we    = 1'b1;
      waddr = slot;
      wdata = rdata;
    end else begin
      we    = (state == S_SCAN) && scan_end && (func_r == F_INSERT) && !full;
      waddr = count[ADDR_W-1:0];
      wdata = key_r;
    end
  end

  isrp_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            func_r  <= func;
            key_r   <= key[KEY_BITS-1:0];
            word    <= random_word;
            idx     <= '0;
            cmp_vld <= 1'b0;
            rem     <= '0;
            div_cnt <= '0;
            case (func)
              F_INSERT, F_ERASE_KEY, F_TEST: begin
                state <= S_SCAN;
              end
              F_ERASE_POS: begin
                if ({1'b0, position} < count) begin
                  slot  <= position;
                  state <= S_RM_RD;
                end else begin
                  done        <= 1'b1;
                  status      <= ST_RANGE;
                  removed_key <= '0;
                  size_after  <= count;
                end
              end
              F_POP: begin
                if (count == '0) begin
                  done        <= 1'b1;
                  status      <= ST_RANGE;
                  removed_key <= '0;
                  size_after  <= count;
                end else begin
                  state <= S_DIV;
                end
              end
              default: begin
                done        <= 1'b1;
                status      <= ST_RANGE;
                removed_key <= '0;
                size_after  <= count;
              end
            endcase
          end
        end
        S_SCAN: begin
          idx     <= idx + CNT_W'(1);
          cmp_vld <= (idx < count);
          cmp_idx <= idx[ADDR_W-1:0];
          if (hit) begin
            case (func_r)
              F_ERASE_KEY: begin
                slot  <= cmp_idx;
                state <= S_RM_RD;
              end
              F_TEST: begin
                done        <= 1'b1;
                status      <= ST_OK;
                removed_key <= '0;
                size_after  <= count;
                state       <= S_IDLE;
              end
              default: begin
                done        <= 1'b1;
                status      <= ST_MISS;
                removed_key <= '0;
                size_after  <= count;
                state       <= S_IDLE;
              end
            endcase
          end else if (scan_end) begin
            done        <= 1'b1;
            removed_key <= '0;
            state       <= S_IDLE;
            if (func_r == F_INSERT) begin
              if (full) begin
                status     <= ST_FULL;
                size_after <= count;
              end else begin
                status     <= ST_OK;
                count      <= count + CNT_W'(1);
                size_after <= count + CNT_W'(1);
              end
            end else begin
              status     <= ST_MISS;
              size_after <= count;
            end
          end
        end
        S_DIV: begin
          word    <= word << 1;
          rem     <= rem_next;
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(WORD_W - 1)) begin
            slot  <= rem_next[ADDR_W-1:0];
            state <= S_RM_RD;
          end
        end
        S_RM_RD: begin
          state <= S_RM_LAST;
        end
        S_RM_LAST: begin
          taken <= rdata;
          state <= S_RM_WR;
        end
        S_RM_WR: begin
          count       <= cnt_m1;
          done        <= 1'b1;
          status      <= ST_OK;
          removed_key <= (func_r == F_ERASE_KEY) ? '0 : KEY_W'(taken);
          size_after  <= cnt_m1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> busy)
    else $error("store written while idle");

  a_count_on_done: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> (done || $past(rst)))
    else $error("entry count changed without a result");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result with no command");
`endif

endmodule

>>> verif/set_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_result_checker
// Watches the command and result channels of indexed_set_random_pop. It keeps
// its own copy of the key store and entry count, predicts the outcome of each
// accepted command and compares every result, field by field, with the
// oldest outstanding outcome.
// ----------------------------------------------------------------------------
module set_result_checker
  import isrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [FUNC_W-1:0] func,
  input  logic [KEY_W-1:0]  key,
  input  logic [POS_W-1:0]  position,
  input  logic [WORD_W-1:0] random_word,
  input  logic              done,
  input  logic [ST_W-1:0]   status,
  input  logic [KEY_W-1:0]  removed_key,
  input  logic [CNT_W-1:0]  size_after,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] removed;
    logic [CNT_W-1:0] size;
  } outcome_t;

  key_t     model_keys [CAPACITY];
  int       model_count;
  outcome_t outcomes [$];

  // Removes slot s, moving the last entry into it; returns the key taken.
  function automatic key_t take_slot(input int s);
    key_t taken;
    taken = model_keys[s];
    model_keys[s] = model_keys[model_count - 1];
    model_count = model_count - 1;
    return taken;
  endfunction

  task automatic apply_command(input logic [FUNC_W-1:0] f, input key_t k,
                               input logic [POS_W-1:0] p,
                               input logic [WORD_W-1:0] w);
    outcome_t         o;
    int               slot;
    logic [WORD_W-1:0] cnt_w;
    o.status  = ST_OK;
    o.removed = '0;
    slot = model_count;
    for (int i = 0; i < model_count; i++) begin
      if (model_keys[i] == k && slot == model_count) slot = i;
    end
    case (f)
      F_INSERT: begin
        if (slot < model_count) o.status = ST_MISS;
        else if (model_count >= CAPACITY) o.status = ST_FULL;
        else begin
          model_keys[model_count] = k;
          model_count = model_count + 1;
        end
      end
      F_ERASE_KEY: begin
        if (slot < model_count) void'(take_slot(slot));
        else o.status = ST_MISS;
      end
      F_TEST: begin
        if (slot >= model_count) o.status = ST_MISS;
      end
      F_ERASE_POS: begin
        if (int'(p) < model_count) o.removed = take_slot(int'(p));
        else o.status = ST_RANGE;
      end
      F_POP: begin
        if (model_count == 0) o.status = ST_RANGE;
        else begin
          cnt_w = WORD_W'(model_count);
          o.removed = take_slot(int'(w % cnt_w));
        end
      end
      default: o.status = ST_RANGE;
    endcase
    o.size = CNT_W'(model_count);
    outcomes = {outcomes, o};
  endtask

  always @(posedge clk) begin
    outcome_t exp;
    if (rst) begin
      outcomes.delete();
      model_count = 0;
      errors = 0;
    end else begin
      if (done) begin
        if (outcomes.size() == 0) begin
          $display("%0t: unexpected result status %0d removed %h size %0d",
                   $time, status, removed_key, size_after);
          errors = errors + 1;
        end else begin
          exp = outcomes.pop_front();
          if (status !== exp.status) begin
            $display("%0t: status expected %0d, got %0d", $time, exp.status, status);
            errors = errors + 1;
          end
          if (removed_key !== exp.removed) begin
            $display("%0t: removed_key expected %h, got %h",
                     $time, exp.removed, removed_key);
            errors = errors + 1;
          end
          if (size_after !== exp.size) begin
            $display("%0t: size_after expected %0d, got %0d",
                     $time, exp.size, size_after);
            errors = errors + 1;
          end
        end
      end
      if (start && !busy) apply_command(func, key[KEY_BITS-1:0], position, random_word);
    end
    pending = outcomes.size();
  end

endmodule

>>> verif/tb_indexed_set_random_pop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_set_random_pop
// Drives commands into indexed_set_random_pop: a directed pass over empty,
// full, duplicate, out-of-range and unknown-func cases, then random rounds
// that lean toward filling, draining or mixing the set, with random idle gaps
// and gap-free stretches. Checking is done by set_result_checker.
// ----------------------------------------------------------------------------
module tb_indexed_set_random_pop;
  import isrp_pkg::*;

  localparam int POOL_SIZE    = 96;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 80;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [FUNC_W-1:0] func = '0;
  logic [KEY_W-1:0]  key = '0;
  logic [POS_W-1:0]  position = '0;
  logic [WORD_W-1:0] random_word = '0;
  logic              done;
  logic [ST_W-1:0]   status;
  logic [KEY_W-1:0]  removed_key;
  logic [CNT_W-1:0]  size_after;
  int                errors;
  int                pending;
  int                cycles = 0;
  int                idle_max = 8;
  logic [KEY_W-1:0]  pool [POOL_SIZE];

  indexed_set_random_pop uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .key(key), .position(position), .random_word(random_word),
    .done(done), .status(status), .removed_key(removed_key),
    .size_after(size_after)
  );

  set_result_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .key(key), .position(position), .random_word(random_word),
    .done(done), .status(status), .removed_key(removed_key),
    .size_after(size_after), .errors(errors), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[indexed_set_random_pop] ERROR");
      $finish;
    end
  end

  // One command transfer, after a random idle gap.
  task automatic issue(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                       input logic [POS_W-1:0] p, input logic [WORD_W-1:0] w);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    func        <= f;
    key         <= k;
    position    <= p;
    random_word <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(input int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 70) return F_INSERT;
        if (r < 78) return F_ERASE_KEY;
        if (r < 86) return F_TEST;
        if (r < 92) return F_ERASE_POS;
        return F_POP;
      end
      1: begin
        if (r < 30) return F_INSERT;
        if (r < 45) return F_ERASE_KEY;
        if (r < 65) return F_TEST;
        if (r < 80) return F_ERASE_POS;
        return F_POP;
      end
      2: begin
        if (r < 15) return F_INSERT;
        if (r < 40) return F_ERASE_KEY;
        if (r < 50) return F_TEST;
        if (r < 70) return F_ERASE_POS;
        return F_POP;
      end
      default: return FUNC_W'($urandom_range(0, 7));
    endcase
  endfunction

  initial begin
    int               issued;
    int               mode;
    int               len;
    bit               clash;
    logic [KEY_W-1:0] v;

    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      do begin
        v = $urandom;
        clash = 1'b0;
        for (int j = 0; j < i; j++) if (pool[j] == v) clash = 1'b1;
      end while (clash);
      pool[i] = v;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store, unknown funcs, extremes
    issue(F_TEST, pool[0], '0, '0);
    issue(F_ERASE_KEY, pool[0], '0, '0);
    issue(F_ERASE_POS, '0, '0, '0);
    issue(F_POP, '0, '0, '1);
    issue(3'd5, '1, '1, '1);
    issue(3'd6, '1, '1, '1);
    issue(3'd7, '1, '1, '1);
    issue(F_INSERT, '0, '0, '0);
    issue(F_INSERT, '1, '0, '0);
    issue(F_INSERT, '0, '0, '0);
    issue(F_TEST, '0, '0, '0);
    issue(F_TEST, '1, '0, '0);
    issue(F_TEST, pool[2], '0, '0);
    issue(F_INSERT, pool[2], '0, '0);
    issue(F_ERASE_POS, '0, '1, '0);
    issue(F_ERASE_POS, '0, '0, '0);
    issue(F_POP, '0, '1, '0);
    issue(F_ERASE_KEY, '1, '0, '0);
    issue(F_ERASE_KEY, pool[3], '0, '0);
    issue(F_POP, '1, '0, '1);

    // empty it, fill to capacity, then full and duplicate-at-full cases
    for (int i = 0; i < CAPACITY; i++) issue(F_POP, '0, '0, $urandom);
    for (int i = 0; i < CAPACITY; i++) issue(F_INSERT, pool[i], '0, '0);
    issue(F_INSERT, pool[CAPACITY], '0, '0);
    issue(F_INSERT, pool[0], '0, '0);
    issue(F_TEST, pool[CAPACITY - 1], '0, '0);
    issue(F_ERASE_POS, '0, '1, '0);
    issue(F_INSERT, pool[CAPACITY], '0, '0);
    issue(F_POP, '0, '0, '1);
    wait_for_drain();

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      mode     = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2);
      len      = $urandom_range(20, 60);
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      if ($urandom_range(0, 4) == 0) wait_for_drain();
      for (int j = 0; j < len && issued < RANDOM_ITEMS; j++) begin
        if (mode == 3)
          issue(pick_func(mode), $urandom, POS_W'($urandom_range(0, 63)), $urandom);
        else
          issue(pick_func(mode), pick_key(), POS_W'($urandom_range(0, 63)),
                pick_word());
        issued++;
      end
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("[indexed_set_random_pop] OK");
    end else begin
      $display("[indexed_set_random_pop] ERROR");
    end
    $finish;
  end

endmodule
